// File: hdl/epa_pkg.sv
// Shared types and constants for the elliptic point adder.
`timescale 1ns / 1ps

package epa_pkg;

  // Field element width
  localparam int FIELD_BITS = 16;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A4 = 2'd2;

  // Register reset values
  localparam logic [FIELD_BITS-1:0] MODULUS_RESET = FIELD_BITS'(349);
  localparam logic [FIELD_BITS-1:0] COEF_RESET    = '0;

  // Smallest usable modulus, and the Fermat exponent offset
  localparam logic [FIELD_BITS-1:0] MOD_MIN      = FIELD_BITS'(3);
  localparam logic [FIELD_BITS-1:0] FERMAT_OFFS  = FIELD_BITS'(2);

  // Shared modular unit operations
  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_cmd_t;

  // Input item: two affine points
  typedef struct packed {
    logic [FIELD_BITS-1:0] first_x;
    logic [FIELD_BITS-1:0] first_y;
    logic                  first_at_infinity;
    logic [FIELD_BITS-1:0] second_x;
    logic [FIELD_BITS-1:0] second_y;
    logic                  second_at_infinity;
  } point_pair_t;

  // Result item: the sum
  typedef struct packed {
    logic [FIELD_BITS-1:0] sum_x;
    logic [FIELD_BITS-1:0] sum_y;
    logic                  sum_at_infinity;
    logic                  inverse_error;
  } point_sum_t;

endpackage

// File: hdl/epa_mod_alu.sv
// Shared modular unit: registered add and subtract, bit-serial multiply mod p.
`timescale 1ns / 1ps

module epa_mod_alu (
  input  logic                           clk,
  input  logic                           rst_n,
  input  epa_pkg::alu_cmd_t              cmd,
  input  logic [epa_pkg::FIELD_BITS-1:0] opa,
  input  logic [epa_pkg::FIELD_BITS-1:0] opb,
  input  logic [epa_pkg::FIELD_BITS-1:0] p,
  output logic [epa_pkg::FIELD_BITS-1:0] result,
  output logic                           done
);
  import epa_pkg::*;

  localparam int W     = FIELD_BITS + 2;
  localparam int CNT_W = $clog2(FIELD_BITS + 1);

  logic                  mul_busy_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [FIELD_BITS-1:0] acc_r;
  logic [FIELD_BITS-1:0] mcand_r;
  logic [FIELD_BITS-1:0] mplier_r;
  logic [FIELD_BITS-1:0] result_r;
  logic                  done_r;

  logic [W-1:0]          p_ext;
  logic [W-1:0]          p2_ext;
  logic [W-1:0]          addend;
  logic [W-1:0]          mul_sum;
  logic [W-1:0]          as_sum;
  logic [W-1:0]          red_in;
  logic [W-1:0]          red;
  logic [FIELD_BITS-1:0] red_out;

  // Operand sums; every one stays below 3p
  always_comb begin
    p_ext   = {2'b00, p};
    p2_ext  = {1'b0, p, 1'b0};
    addend  = mplier_r[FIELD_BITS-1] ? {2'b00, mcand_r} : '0;
    mul_sum = {1'b0, acc_r, 1'b0} + addend;
    if (cmd.op == ALU_SUB) begin
      as_sum = {2'b00, opa} + p_ext - {2'b00, opb};
    end else begin
      as_sum = {2'b00, opa} + {2'b00, opb};
    end
    red_in = mul_busy_r ? mul_sum : as_sum;
  end

  // Shared reduction: take off 2p or p
  always_comb begin
    if (red_in >= p2_ext) begin
      red = red_in - p2_ext;
    end else if (red_in >= p_ext) begin
      red = red_in - p_ext;
    end else begin
      red = red_in;
    end
    red_out = red[FIELD_BITS-1:0];
  end

  // Sequencing: multiply scans the multiplier MSB first, one bit a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (mul_busy_r) begin
        acc_r    <= red_out;
        mplier_r <= {mplier_r[FIELD_BITS-2:0], 1'b0};
        cnt_r    <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          mul_busy_r <= 1'b0;
          done_r     <= 1'b1;
          result_r   <= red_out;
        end
      end else if (cmd.start) begin
        case (cmd.op)
          ALU_MUL: begin
            mul_busy_r <= 1'b1;
            acc_r      <= '0;
            mcand_r    <= opa;
            mplier_r   <= opb;
            cnt_r      <= CNT_W'(FIELD_BITS);
          end
          ALU_ADD, ALU_SUB: begin
            result_r <= red_out;
            done_r   <= 1'b1;
          end
          default: begin
            result_r <= opa;
            done_r   <= 1'b1;
          end
        endcase
      end
    end
  end

  assign result = result_r;
  assign done   = done_r;

endmodule

// File: hdl/elliptic_point_add_mod_p.sv
// Top level of the affine point adder over a configurable prime field.
`timescale 1ns / 1ps

// Adds two affine points on y^2 = x^3 + a2*x^2 + a4*x + a6 mod p, one item at a time;
// in_ready is high only while the block is idle. All arithmetic runs through one
// shared modular unit: an add or subtract is registered, and a multiply is bit-serial
// (one multiplier bit a cycle). An item costs six multiplies to reduce its operands
// and coefficients. A full addition adds the slope, the Fermat inversion (up to
// 2*FIELD_BITS-2 multiplies, since p-2 has at most FIELD_BITS-1 bits set) and the
// final products; the inversion loop through the bit-serial multiplier dominates.
// A stalled result register holds the next item off until the sum is taken. The
// modulus is taken as 3 when written below 3. A zero slope denominator returns
// infinity with inverse_error set. Registers are written through the cfg port,
// which is always ready, and must only change while the block is idle.

module elliptic_point_add_mod_p (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  epa_pkg::point_pair_t             in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output epa_pkg::point_sum_t              out_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [epa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [epa_pkg::FIELD_BITS-1:0]   cfg_data
);
  import epa_pkg::*;

  localparam int IDX_W = $clog2(FIELD_BITS);

  typedef enum logic [5:0] {
    S_IDLE,
    S_RED_AX, S_RED_AY, S_RED_BX, S_RED_BY, S_RED_A2, S_RED_A4,
    S_DECIDE,
    S_D1, S_D2, S_D3, S_D4, S_D5, S_D6, S_D7, S_D8,
    S_C1, S_C2,
    S_CHKDEN,
    S_INV_MUL, S_INV_SQ,
    S_LAM,
    S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_F7,
    S_DONE
  } state_t;

  // Configuration registers
  logic [FIELD_BITS-1:0] modulus_r;
  logic [FIELD_BITS-1:0] coef_a2_r;
  logic [FIELD_BITS-1:0] coef_a4_r;

  // Control
  state_t                state_r, state_nxt;
  logic                  issued_r;
  logic [IDX_W-1:0]      idx_r;
  logic                  out_valid_r;
  point_sum_t            out_item_r;

  // Working registers
  point_pair_t           in_r;
  logic [FIELD_BITS-1:0] p_r, exp_r;
  logic [FIELD_BITS-1:0] ax_r, ay_r, bx_r, by_r, a2_r, a4_r;
  logic [FIELD_BITS-1:0] num_r, den_r, tmp_r, lam_r, rp_r, bp_r;
  logic [FIELD_BITS-1:0] res_x_r, res_y_r;
  logic                  res_inf_r, res_err_r;

  // Shared unit
  alu_cmd_t              alu_cmd;
  logic [FIELD_BITS-1:0] alu_a, alu_b, alu_res;
  logic                  alu_done;
  logic                  op_req;

  logic [FIELD_BITS-1:0] p_eff;
  logic                  same_x, same_y, negated, last_bit, exp_bit;

  epa_mod_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (alu_cmd),
    .opa    (alu_a),
    .opb    (alu_b),
    .p      (p_r),
    .result (alu_res),
    .done   (alu_done)
  );

  // Case tests on the reduced operands
  always_comb begin
    p_eff    = (modulus_r < MOD_MIN) ? MOD_MIN : modulus_r;
    same_x   = (ax_r == bx_r);
    same_y   = (ay_r == by_r);
    negated  = (({1'b0, ay_r} + {1'b0, by_r}) == {1'b0, p_r}) ||
               ((ay_r == '0) && (by_r == '0));
    last_bit = (idx_r == IDX_W'(FIELD_BITS - 1));
    exp_bit  = exp_r[idx_r];
  end

  // Operation select for the current step
  always_comb begin
    op_req = 1'b1;
    alu_a  = '0;
    alu_b  = '0;
    alu_cmd.op = ALU_ADD;
    case (state_r)
      S_RED_AX:  begin alu_cmd.op = ALU_MUL; alu_a = FIELD_BITS'(1); alu_b = in_r.first_x;  end
      S_RED_AY:  begin alu_cmd.op = ALU_MUL; alu_a = FIELD_BITS'(1); alu_b = in_r.first_y;  end
      S_RED_BX:  begin alu_cmd.op = ALU_MUL; alu_a = FIELD_BITS'(1); alu_b = in_r.second_x; end
      S_RED_BY:  begin alu_cmd.op = ALU_MUL; alu_a = FIELD_BITS'(1); alu_b = in_r.second_y; end
      S_RED_A2:  begin alu_cmd.op = ALU_MUL; alu_a = FIELD_BITS'(1); alu_b = coef_a2_r;     end
      S_RED_A4:  begin alu_cmd.op = ALU_MUL; alu_a = FIELD_BITS'(1); alu_b = coef_a4_r;     end
      // tangent slope numerator 3x^2 + 2*a2*x + a4, denominator 2y
      S_D1:      begin alu_cmd.op = ALU_MUL; alu_a = ax_r;  alu_b = ax_r;  end
      S_D2:      begin alu_cmd.op = ALU_ADD; alu_a = tmp_r; alu_b = tmp_r; end
      S_D3:      begin alu_cmd.op = ALU_ADD; alu_a = num_r; alu_b = tmp_r; end
      S_D4:      begin alu_cmd.op = ALU_ADD; alu_a = a2_r;  alu_b = a2_r;  end
      S_D5:      begin alu_cmd.op = ALU_MUL; alu_a = tmp_r; alu_b = ax_r;  end
      S_D6:      begin alu_cmd.op = ALU_ADD; alu_a = num_r; alu_b = tmp_r; end
      S_D7:      begin alu_cmd.op = ALU_ADD; alu_a = num_r; alu_b = a4_r;  end
      S_D8:      begin alu_cmd.op = ALU_ADD; alu_a = ay_r;  alu_b = ay_r;  end
      // chord slope
      S_C1:      begin alu_cmd.op = ALU_SUB; alu_a = by_r;  alu_b = ay_r;  end
      S_C2:      begin alu_cmd.op = ALU_SUB; alu_a = bx_r;  alu_b = ax_r;  end
      // Fermat inversion, exponent bits LSB first
      S_INV_MUL: begin alu_cmd.op = ALU_MUL; alu_a = rp_r;  alu_b = bp_r; op_req = exp_bit; end
      S_INV_SQ:  begin alu_cmd.op = ALU_MUL; alu_a = bp_r;  alu_b = bp_r; op_req = !last_bit; end
      S_LAM:     begin alu_cmd.op = ALU_MUL; alu_a = num_r; alu_b = rp_r;  end
      // x3 = lam^2 - a2 - ax - bx, y3 = lam*(ax - x3) - ay
      S_F1:      begin alu_cmd.op = ALU_MUL; alu_a = lam_r; alu_b = lam_r;   end
      S_F2:      begin alu_cmd.op = ALU_SUB; alu_a = tmp_r; alu_b = a2_r;    end
      S_F3:      begin alu_cmd.op = ALU_SUB; alu_a = tmp_r; alu_b = ax_r;    end
      S_F4:      begin alu_cmd.op = ALU_SUB; alu_a = tmp_r; alu_b = bx_r;    end
      S_F5:      begin alu_cmd.op = ALU_SUB; alu_a = ax_r;  alu_b = res_x_r; end
      S_F6:      begin alu_cmd.op = ALU_MUL; alu_a = lam_r; alu_b = tmp_r;   end
      S_F7:      begin alu_cmd.op = ALU_SUB; alu_a = tmp_r; alu_b = ay_r;    end
      default:   op_req = 1'b0;
    endcase
    alu_cmd.start = op_req && !issued_r;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_RED_AX;
      S_RED_AX:  if (alu_done) state_nxt = S_RED_AY;
      S_RED_AY:  if (alu_done) state_nxt = S_RED_BX;
      S_RED_BX:  if (alu_done) state_nxt = S_RED_BY;
      S_RED_BY:  if (alu_done) state_nxt = S_RED_A2;
      S_RED_A2:  if (alu_done) state_nxt = S_RED_A4;
      S_RED_A4:  if (alu_done) state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (in_r.first_at_infinity || in_r.second_at_infinity) begin
          state_nxt = S_DONE;
        end else if (same_x && negated) begin
          state_nxt = S_DONE;
        end else if (same_x && same_y) begin
          state_nxt = S_D1;
        end else begin
          state_nxt = S_C1;
        end
      end
      S_D1:      if (alu_done) state_nxt = S_D2;
      S_D2:      if (alu_done) state_nxt = S_D3;
      S_D3:      if (alu_done) state_nxt = S_D4;
      S_D4:      if (alu_done) state_nxt = S_D5;
      S_D5:      if (alu_done) state_nxt = S_D6;
      S_D6:      if (alu_done) state_nxt = S_D7;
      S_D7:      if (alu_done) state_nxt = S_D8;
      S_D8:      if (alu_done) state_nxt = S_CHKDEN;
      S_C1:      if (alu_done) state_nxt = S_C2;
      S_C2:      if (alu_done) state_nxt = S_CHKDEN;
      S_CHKDEN:  state_nxt = (den_r == '0) ? S_DONE : S_INV_MUL;
      S_INV_MUL: if (!exp_bit || alu_done) state_nxt = S_INV_SQ;
      S_INV_SQ: begin
        if (last_bit) begin
          state_nxt = S_LAM;
        end else if (alu_done) begin
          state_nxt = S_INV_MUL;
        end
      end
      S_LAM:     if (alu_done) state_nxt = S_F1;
      S_F1:      if (alu_done) state_nxt = S_F2;
      S_F2:      if (alu_done) state_nxt = S_F3;
      S_F3:      if (alu_done) state_nxt = S_F4;
      S_F4:      if (alu_done) state_nxt = S_F5;
      S_F5:      if (alu_done) state_nxt = S_F6;
      S_F6:      if (alu_done) state_nxt = S_F7;
      S_F7:      if (alu_done) state_nxt = S_DONE;
      S_DONE:    if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // State, configuration, working registers and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      modulus_r   <= MODULUS_RESET;
      coef_a2_r   <= COEF_RESET;
      coef_a4_r   <= COEF_RESET;
    end else begin
      state_r <= state_nxt;

      // configuration writes
      if (cfg_valid) begin
        case (cfg_index)
          REG_MODULUS: modulus_r <= cfg_data;
          REG_COEF_A2: coef_a2_r <= cfg_data;
          REG_COEF_A4: coef_a4_r <= cfg_data;
          default: ;
        endcase
      end

      // issue tracking for the shared unit
      if (alu_done) begin
        issued_r <= 1'b0;
      end else if (alu_cmd.start) begin
        issued_r <= 1'b1;
      end

      // result handover: load a new sum, or drop valid once taken
      if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            in_r  <= in_item;
            p_r   <= p_eff;
            exp_r <= p_eff - FERMAT_OFFS;
          end
        end
        S_RED_AX: if (alu_done) ax_r <= alu_res;
        S_RED_AY: if (alu_done) ay_r <= alu_res;
        S_RED_BX: if (alu_done) bx_r <= alu_res;
        S_RED_BY: if (alu_done) by_r <= alu_res;
        S_RED_A2: if (alu_done) a2_r <= alu_res;
        S_RED_A4: if (alu_done) a4_r <= alu_res;
        S_DECIDE: begin
          res_err_r <= 1'b0;
          if (in_r.first_at_infinity && in_r.second_at_infinity) begin
            res_x_r <= '0;   res_y_r <= '0;   res_inf_r <= 1'b1;
          end else if (in_r.first_at_infinity) begin
            res_x_r <= bx_r; res_y_r <= by_r; res_inf_r <= 1'b0;
          end else if (in_r.second_at_infinity) begin
            res_x_r <= ax_r; res_y_r <= ay_r; res_inf_r <= 1'b0;
          end else begin
            res_x_r <= '0;   res_y_r <= '0;   res_inf_r <= 1'b1;
          end
        end
        S_D1, S_D4, S_D5:
                  if (alu_done) tmp_r <= alu_res;
        S_D2, S_D3, S_D6, S_D7, S_C1:
                  if (alu_done) num_r <= alu_res;
        S_D8, S_C2:
                  if (alu_done) den_r <= alu_res;
        S_CHKDEN: begin
          // zero denominator: infinity with the error flag
          res_x_r   <= '0;
          res_y_r   <= '0;
          res_inf_r <= 1'b1;
          res_err_r <= 1'b1;
          rp_r      <= FIELD_BITS'(1);
          bp_r      <= den_r;
          idx_r     <= '0;
        end
        S_INV_MUL: if (alu_done) rp_r <= alu_res;
        S_INV_SQ: begin
          if (alu_done) begin
            bp_r  <= alu_res;
            idx_r <= idx_r + IDX_W'(1);
          end
        end
        S_LAM:    if (alu_done) lam_r <= alu_res;
        S_F1, S_F2, S_F3, S_F5, S_F6:
                  if (alu_done) tmp_r <= alu_res;
        S_F4:     if (alu_done) res_x_r <= alu_res;
        S_F7: begin
          if (alu_done) begin
            res_y_r   <= alu_res;
            res_inf_r <= 1'b0;
            res_err_r <= 1'b0;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_item_r.sum_x           <= res_x_r;
            out_item_r.sum_y           <= res_y_r;
            out_item_r.sum_at_infinity <= res_inf_r;
            out_item_r.inverse_error   <= res_err_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign cfg_ready = 1'b1;

  // Checks
  a_inf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_item.sum_at_infinity ||
                   ((out_item.sum_x == '0) && (out_item.sum_y == '0))))
    else $error("sum at infinity with nonzero coordinates");

  a_err_inf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.inverse_error) |-> out_item.sum_at_infinity)
    else $error("inverse error without infinity");

  a_done_issued: assert property (@(posedge clk) disable iff (!rst_n)
    alu_done |-> issued_r)
    else $error("modular unit finished an operation never issued");

  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> ((state_r == S_RED_AX) && !issued_r))
    else $error("accepted item did not start operand reduction");

endmodule

// File: tb/sv/epa_sum_checker.sv
// Scoreboard for the elliptic point adder: predicts every sum and checks the result channel.
`timescale 1ns / 1ps

module epa_sum_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  epa_pkg::point_pair_t           in_item,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  epa_pkg::point_sum_t            out_item,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [epa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [epa_pkg::FIELD_BITS-1:0] cfg_data,
  output int                             fail_count,
  output int                             sums_owed,
  output int                             pairs_seen,
  output int                             sums_checked,
  output int                             infinities_seen,
  output int                             inverse_errors_seen
);
  import epa_pkg::*;

  // Local copy of the field and curve registers
  logic [FIELD_BITS-1:0] modulus_q;
  logic [FIELD_BITS-1:0] coef_a2_q;
  logic [FIELD_BITS-1:0] coef_a4_q;

  // Sums still owed by the block, oldest first
  point_sum_t predicted_sums[$];

  function automatic logic [63:0] add_mod(logic [63:0] a, logic [63:0] b, logic [63:0] p);
    return (a + b) % p;
  endfunction

  function automatic logic [63:0] sub_mod(logic [63:0] a, logic [63:0] b, logic [63:0] p);
    return (a + p - b) % p;
  endfunction

  function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] p);
    return (a * b) % p;
  endfunction

  // Square-and-multiply over the full field width, low bit first
  function automatic logic [63:0] pow_mod(logic [63:0] base, logic [63:0] e, logic [63:0] p);
    logic [63:0] acc;
    logic [63:0] sq;
    acc = 64'd1 % p;
    sq  = base % p;
    for (int i = 0; i < FIELD_BITS; i++) begin
      if (e[i]) acc = mul_mod(acc, sq, p);
      sq = mul_mod(sq, sq, p);
    end
    return acc;
  endfunction

  // Affine sum of one point pair under the current registers
  function automatic point_sum_t add_points(point_pair_t pr);
    logic [63:0] p, ax, ay, bx, by, a2, a4;
    logic [63:0] num, den, lam, x3, y3;
    point_sum_t  r;
    p  = (modulus_q < MOD_MIN) ? 64'(MOD_MIN) : 64'(modulus_q);
    ax = 64'(pr.first_x) % p;
    ay = 64'(pr.first_y) % p;
    bx = 64'(pr.second_x) % p;
    by = 64'(pr.second_y) % p;
    a2 = 64'(coef_a2_q) % p;
    a4 = 64'(coef_a4_q) % p;
    r  = '0;
    // an operand at infinity passes the other point through
    if (pr.first_at_infinity) begin
      r.sum_at_infinity = pr.second_at_infinity;
      if (!pr.second_at_infinity) begin
        r.sum_x = bx[FIELD_BITS-1:0];
        r.sum_y = by[FIELD_BITS-1:0];
      end
      return r;
    end
    if (pr.second_at_infinity) begin
      r.sum_x = ax[FIELD_BITS-1:0];
      r.sum_y = ay[FIELD_BITS-1:0];
      return r;
    end
    // P + (-P)
    if (ax == bx && add_mod(ay, by, p) == 0) begin
      r.sum_at_infinity = 1'b1;
      return r;
    end
    if (ax == bx && ay == by) begin
      // doubling a point of order two
      if (ay == 0) begin
        r.sum_at_infinity = 1'b1;
        return r;
      end
      // tangent: (3x^2 + 2*a2*x + a4) / 2y
      num = mul_mod(64'd3, mul_mod(ax, ax, p), p);
      num = add_mod(num, mul_mod(mul_mod(64'd2, a2, p), ax, p), p);
      num = add_mod(num, a4, p);
      den = mul_mod(64'd2, ay, p);
    end else begin
      num = sub_mod(by, ay, p);
      den = sub_mod(bx, ax, p);
    end
    if (den == 0) begin
      r.sum_at_infinity = 1'b1;
      r.inverse_error   = 1'b1;
      return r;
    end
    lam = mul_mod(num, pow_mod(den, p - 64'(FERMAT_OFFS), p), p);
    x3  = sub_mod(sub_mod(sub_mod(mul_mod(lam, lam, p), a2, p), ax, p), bx, p);
    y3  = sub_mod(mul_mod(lam, sub_mod(ax, x3, p), p), ay, p);
    r.sum_x = x3[FIELD_BITS-1:0];
    r.sum_y = y3[FIELD_BITS-1:0];
    return r;
  endfunction

  function automatic int field_differs(string name, logic [FIELD_BITS-1:0] want,
                                       logic [FIELD_BITS-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Track registers, queue predictions, compare sums
  always @(posedge clk) begin
    if (!rst_n) begin
      modulus_q <= MODULUS_RESET;
      coef_a2_q <= COEF_RESET;
      coef_a4_q <= COEF_RESET;
      predicted_sums.delete();
      sums_owed <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODULUS: modulus_q <= cfg_data;
          REG_COEF_A2: coef_a2_q <= cfg_data;
          REG_COEF_A4: coef_a4_q <= cfg_data;
          default: ;
        endcase
      end
      // a result can never belong to the item taken at the same edge, so check first
      if (out_valid && out_ready) begin
        if (predicted_sums.size() == 0) begin
          $display("%0t: unexpected sum, expected none actual %h", $time, out_item);
          fail_count++;
        end else begin
          point_sum_t want;
          want = predicted_sums.pop_front();
          fail_count += field_differs("sum_x", want.sum_x, out_item.sum_x);
          fail_count += field_differs("sum_y", want.sum_y, out_item.sum_y);
          fail_count += field_differs("sum_at_infinity",
                                      FIELD_BITS'(want.sum_at_infinity),
                                      FIELD_BITS'(out_item.sum_at_infinity));
          fail_count += field_differs("inverse_error",
                                      FIELD_BITS'(want.inverse_error),
                                      FIELD_BITS'(out_item.inverse_error));
          sums_checked++;
          if (want.sum_at_infinity) infinities_seen++;
          if (want.inverse_error) inverse_errors_seen++;
        end
      end
      if (in_valid && in_ready) begin
        predicted_sums = {predicted_sums, add_points(in_item)};
        pairs_seen++;
      end
      sums_owed <= predicted_sums.size();
    end
  end

endmodule

// File: tb/sv/tb_elliptic_point_add_mod_p.sv
// Testbench top for the elliptic point adder: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_elliptic_point_add_mod_p;
  import epa_pkg::*;

  localparam int QUIET_LIMIT = 20000;  // cycles with no handshake before giving up
  localparam int SETTLE      = 16;     // idle cycles before a register write
  localparam int TAIL_CYCLES = 800;    // tail after the final drain
  localparam int HOLD_OFF    = 2000;   // long receiver stall

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  point_pair_t           in_item   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  point_sum_t            out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_MODULUS;
  logic [FIELD_BITS-1:0] cfg_data  = '0;

  int fail_count, sums_owed, pairs_seen, sums_checked;
  int infinities_seen, inverse_errors_seen;

  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;
  int hold_cycles_req = 0;
  int settings_used   = 1;
  int quiet_cycles    = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  elliptic_point_add_mod_p u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  epa_sum_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_item             (in_item),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_item            (out_item),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .fail_count          (fail_count),
    .sums_owed           (sums_owed),
    .pairs_seen          (pairs_seen),
    .sums_checked        (sums_checked),
    .infinities_seen     (infinities_seen),
    .inverse_errors_seen (inverse_errors_seen)
  );

  // Watchdog: too long without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: random stalls, or a long hold-off when asked
  initial begin
    int hold_n;
    forever begin
      @(posedge clk);
      if (hold_cycles_req > 0) begin
        hold_n          = hold_cycles_req;
        hold_cycles_req = 0;
        out_ready <= 1'b0;
        repeat (hold_n) @(posedge clk);
      end else begin
        out_ready <= (rst_n && $urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic point_pair_t make_pair(int ax, int ay, bit ainf, int bx, int by, bit binf);
    point_pair_t pr;
    pr.first_x            = FIELD_BITS'(ax);
    pr.first_y            = FIELD_BITS'(ay);
    pr.first_at_infinity  = ainf;
    pr.second_x           = FIELD_BITS'(bx);
    pr.second_y           = FIELD_BITS'(by);
    pr.second_at_infinity = binf;
    return pr;
  endfunction

  // Sometimes add a multiple of p to a reduced coordinate, while it still fits
  function automatic logic [FIELD_BITS-1:0] lift(logic [FIELD_BITS-1:0] v, int unsigned p);
    int unsigned room;
    room = (65535 - int'(v)) / p;
    if (room > 0 && $urandom_range(5) == 0)
      return FIELD_BITS'(int'(v) + p * $urandom_range(room, 1));
    return v;
  endfunction

  // Mostly well-formed pairs of each kind, with some raw noise
  function automatic point_pair_t random_pair(int unsigned p);
    int unsigned kind;
    point_pair_t pr;
    kind = $urandom_range(99);
    pr = make_pair($urandom_range(p - 1), $urandom_range(p - 1), 1'b0,
                   $urandom_range(p - 1), $urandom_range(p - 1), 1'b0);
    if (kind < 5) begin
      pr.first_at_infinity = 1'b1;
    end else if (kind < 10) begin
      pr.second_at_infinity = 1'b1;
    end else if (kind < 13) begin
      pr.first_at_infinity  = 1'b1;
      pr.second_at_infinity = 1'b1;
    end else if (kind < 28) begin
      // doubling, now and then of a point with y = 0
      if ($urandom_range(7) == 0) pr.first_y = '0;
      pr.second_x = pr.first_x;
      pr.second_y = pr.first_y;
    end else if (kind < 36) begin
      pr.second_x = pr.first_x;
      pr.second_y = FIELD_BITS'((p - pr.first_y) % p);
    end else if (kind < 43) begin
      // same x, unrelated y: usually a zero denominator
      pr.second_x = pr.first_x;
    end else if (kind >= 90) begin
      pr = make_pair($urandom_range(65535), $urandom_range(65535), $urandom_range(1),
                     $urandom_range(65535), $urandom_range(65535), $urandom_range(1));
      return pr;
    end
    pr.first_x  = lift(pr.first_x, p);
    pr.first_y  = lift(pr.first_y, p);
    pr.second_x = lift(pr.second_x, p);
    pr.second_y = lift(pr.second_y, p);
    return pr;
  endfunction

  task automatic send_item(point_pair_t pr);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= pr;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every sum has been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (sums_owed == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= FIELD_BITS'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(int modulus, int a2, int a4, int n_items, int spct, int rpct,
                           int hold_at, int pause_at);
    int unsigned p;
    wait_drained();
    write_reg(REG_MODULUS, modulus);
    write_reg(REG_COEF_A2, a2);
    write_reg(REG_COEF_A4, a4);
    settings_used++;
    send_idle_pct = spct;
    recv_idle_pct = rpct;
    p = (modulus < 3) ? 3 : modulus;
    for (int i = 0; i < n_items; i++) begin
      if (i == hold_at) hold_cycles_req = HOLD_OFF;
      if (i == pause_at) wait_drained();
      send_item(random_pair(p));
    end
  endtask

  // Stimulus and verdict
  initial begin
    send_idle_pct = 24;
    recv_idle_pct = 83;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pairs under the reset field (p = 349, a2 = a4 = 0)
    send_item(make_pair(65535, 65535, 1'b1, 65535, 65535, 1'b1));
    send_item(make_pair(123, 45, 1'b1, 65535, 0, 1'b0));
    send_item(make_pair(0, 65535, 1'b0, 1, 1, 1'b1));
    send_item(make_pair(5, 10, 1'b0, 5, 339, 1'b0));
    send_item(make_pair(5, 10, 1'b0, 354, 688, 1'b0));
    send_item(make_pair(7, 0, 1'b0, 7, 0, 1'b0));
    send_item(make_pair(0, 0, 1'b0, 0, 0, 1'b0));
    send_item(make_pair(3, 4, 1'b0, 3, 4, 1'b0));
    send_item(make_pair(354, 10, 1'b0, 5, 359, 1'b0));
    send_item(make_pair(65535, 65535, 1'b0, 65535, 65535, 1'b0));
    send_item(make_pair(1, 2, 1'b0, 5, 9, 1'b0));
    send_item(make_pair(0, 0, 1'b0, 1, 1, 1'b0));
    send_item(make_pair(348, 348, 1'b0, 0, 1, 1'b0));
    send_item(make_pair(5, 10, 1'b0, 5, 20, 1'b0));
    send_item(make_pair(65535, 0, 1'b0, 272, 100, 1'b0));

    // random phases over extreme and ordinary field settings
    run_phase(65521, 65520, 65520, 50, 24, 83, 5, -1);
    run_phase(3, 65535, 0, 35, 24, 83, -1, -1);
    run_phase(0, 1, 2, 30, 83, 24, -1, -1);
    run_phase(10, 3, 7, 50, 83, 24, -1, 25);
    run_phase(65535, $urandom_range(65535), $urandom_range(65535), 60, 83, 24, -1, -1);
    run_phase(97, 0, 65535, 60, 0, 0, -1, -1);
    run_phase(2, 65534, 5, 25, 0, 0, -1, -1);
    run_phase(1, 40000, 9, 20, 0, 0, -1, -1);
    run_phase(4093, $urandom_range(65535), $urandom_range(65535), 70, 0, 0, -1, -1);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d point pairs over %0d field settings, moduli from 3 to 65535.",
             pairs_seen, settings_used);
    $display("Checked %0d sums: %0d at infinity, %0d with an inverse error.",
             sums_checked, infinities_seen, inverse_errors_seen);
    if (fail_count == 0 && sums_owed == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
